FILE: src/grid_local_maximum_finder_defines.svh
// ----------------------------------------------------------------------------
// grid local maximum finder: assertion macros
// shared property shapes for the block's checkers
// ----------------------------------------------------------------------------
`ifndef GRID_LOCAL_MAXIMUM_FINDER_DEFINES_SVH
`define GRID_LOCAL_MAXIMUM_FINDER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define GLMF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GLMF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// types, constants and record layouts of the grid local maximum finder
// ----------------------------------------------------------------------------
package glmf_pkg;

	localparam int MAX_SIDE_DEF    = 1024;
	localparam int HEIGHT_BITS_DEF = 16;

	// configuration register
	localparam int                SIDE_W        = 11;
	localparam logic [SIDE_W-1:0] SIDE_RESET    = 11'd1024;
	localparam int                APB_AW        = 3;
	localparam logic [0:0]        REG_GRID_SIDE = 1'b0;

	// result record field widths
	localparam int OUT_H_W    = 16;
	localparam int IDX_OUT_W  = 10;
	localparam int TOTAL_W    = 20;
	localparam int COUNT_W    = 21;
	localparam int OUT_DATA_W = 56;

	// record kinds
	localparam logic KIND_PEAK  = 1'b0;
	localparam logic KIND_TOTAL = 1'b1;

	// output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;

	typedef struct packed {
		logic                 kind;
		logic [OUT_H_W-1:0]   height;
		logic [IDX_OUT_W-1:0] row;
		logic [IDX_OUT_W-1:0] col;
		logic [TOTAL_W-1:0]   total;
		logic                 last;
	} glmf_rec_t;

	// per-sample control handed from the address stage to the window stage
	typedef struct packed {
		logic                 valid;
		logic                 test;
		logic                 is_final;
		logic [IDX_OUT_W-1:0] row;
		logic [IDX_OUT_W-1:0] col;
	} glmf_ctl_t;

	// up to two records produced by one sample
	typedef struct packed {
		logic [1:0] cnt;
		glmf_rec_t  first;
		glmf_rec_t  second;
	} glmf_push_t;

endpackage

FILE: src/glmf_ram.sv
// ----------------------------------------------------------------------------
// glmf_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module glmf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/glmf_peak.sv
// ----------------------------------------------------------------------------
// glmf_peak
// 3x3 window registers, strict maximum test and peak counter
// ----------------------------------------------------------------------------
module glmf_peak import glmf_pkg::*; #(
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          restart,
	input  glmf_ctl_t                     ctl,
	input  logic signed [HEIGHT_BITS-1:0] sample,
	input  logic signed [HEIGHT_BITS-1:0] upper,
	input  logic signed [HEIGHT_BITS-1:0] middle,
	output glmf_push_t                    push
);

	// rows top, middle, bottom; two columns each (c-2, c-1)
	logic signed [HEIGHT_BITS-1:0] win_q [6];
	logic [COUNT_W-1:0]            count_q;

	logic signed [HEIGHT_BITS-1:0] ctr;
	logic                          peak;
	logic [COUNT_W-1:0]            count_inc;
	glmf_rec_t                     peak_rec;
	glmf_rec_t                     tot_rec;

	always_comb begin
		ctr  = win_q[3];
		peak = ctl.test &&
			(win_q[0] < ctr) && (win_q[1] < ctr) && (upper  < ctr) &&
			(win_q[2] < ctr) &&                     (middle < ctr) &&
			(win_q[4] < ctr) && (win_q[5] < ctr) && (sample < ctr);
		count_inc = count_q + COUNT_W'(peak);

		peak_rec        = '0;
		peak_rec.kind   = KIND_PEAK;
		peak_rec.height = OUT_H_W'($unsigned(ctr));
		peak_rec.row    = ctl.row;
		peak_rec.col    = ctl.col;
		peak_rec.last   = !ctl.is_final;

		tot_rec       = '0;
		tot_rec.kind  = KIND_TOTAL;
		tot_rec.total = count_inc[TOTAL_W-1:0];
		tot_rec.last  = 1'b1;

		push = '0;
		if (ctl.valid) begin
			if (peak) begin
				push.first = peak_rec;
				push.cnt   = 2'd1;
				if (ctl.is_final) begin
					push.second = tot_rec;
					push.cnt    = 2'd2;
				end
			end else if (ctl.is_final) begin
				push.first = tot_rec;
				push.cnt   = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart) begin
			count_q <= '0;
		end else if (ctl.valid) begin
			win_q[0] <= win_q[1];
			win_q[1] <= upper;
			win_q[2] <= win_q[3];
			win_q[3] <= middle;
			win_q[4] <= win_q[5];
			win_q[5] <= sample;
			count_q  <= ctl.is_final ? '0 : count_inc;
		end
	end

endmodule

FILE: src/glmf_fifo.sv
// ----------------------------------------------------------------------------
// glmf_fifo
// result queue, takes up to two records a cycle, gives one
// ----------------------------------------------------------------------------
module glmf_fifo import glmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  glmf_push_t         push,
	input  logic               pop,
	output glmf_rec_t          head,
	output logic               not_empty,
	output logic [FIFO_AW:0]   count
);

	glmf_rec_t            slot_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_q;
	logic [FIFO_AW-1:0]   rd_q;
	logic [FIFO_AW:0]     cnt_q;

	always_ff @(posedge clk) begin
		case (push.cnt)
			2'd1: begin
				slot_q[wr_q] <= push.first;
			end
			2'd2: begin
				slot_q[wr_q]                      <= push.first;
				slot_q[FIFO_AW'(wr_q + 1'b1)]     <= push.second;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= FIFO_AW'(wr_q + FIFO_AW'(push.cnt));
			rd_q  <= FIFO_AW'(rd_q + FIFO_AW'(pop));
			cnt_q <= (FIFO_AW+1)'(cnt_q + (FIFO_AW+1)'(push.cnt) - (FIFO_AW+1)'(pop));
		end
	end

	assign head      = slot_q[rd_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

endmodule

FILE: src/grid_local_maximum_finder.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// strict 3x3 local maximum search over a square height grid
// ----------------------------------------------------------------------------
// Heights arrive in raster order, one signed sample per request, over a grid
// of grid_side x grid_side cells (register 0; 0 acts as 1, values above
// MAX_SIDE act as MAX_SIDE). One sample is taken every clock cycle while the
// result queue has room; a peak record passes stage 1 and the queue before
// it leaves. The rate is set by the two line-buffer rams (rows r-2 and
// r-1), each read and written once per sample at the sample's column. A
// cell is a peak when it is strictly greater than all eight neighbors;
// border cells never are. Peaks come out in raster order with height, row
// and column; after the final sample of the grid a total record (tuser = 1)
// carries the peak count, with tlast on the last record of each sample. The
// output side is buffered by an eight-entry queue; the input stalls only
// when the queue cannot take the worst case of the samples in flight.
// Writing grid_side restarts the grid at row 0, column 0; write it only
// while no sample is in flight. The line buffers need no clearing: rows 0
// and 1 of every grid fill them before any test reads them.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder import glmf_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF,
	localparam int IN_DATA_W  = ((HEIGHT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_AW-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// sample stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // height
	// result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // peak_height, peak_row, peak_col, total
	output logic [0:0]            m_axis_tuser,   // kind
	output logic                  m_axis_tlast
);

	localparam int IDX_W = $clog2(MAX_SIDE);
	localparam int CMP_W = (IDX_W + 1 > SIDE_W) ? IDX_W + 1 : SIDE_W;

	// configuration and position
	logic [SIDE_W-1:0] side_q;
	logic [IDX_W-1:0]  row_q;
	logic [IDX_W-1:0]  col_q;

	logic              cfg_wr;
	logic              restart;
	logic [CMP_W-1:0]  eff_side;
	logic              last_col;
	logic              last_row;
	logic              is_final;
	logic              accept;

	logic signed [HEIGHT_BITS-1:0] sample_in;

	// window stage
	glmf_ctl_t                     ctl_s1;
	logic signed [HEIGHT_BITS-1:0] sample_s1;
	logic [IDX_W-1:0]              addr_s1;
	logic                          fwd_s1;
	logic signed [HEIGHT_BITS-1:0] fwd_up_s1;
	logic signed [HEIGHT_BITS-1:0] fwd_mid_s1;

	logic [HEIGHT_BITS-1:0]        up_rdata;
	logic [HEIGHT_BITS-1:0]        mid_rdata;
	logic signed [HEIGHT_BITS-1:0] upper_val;
	logic signed [HEIGHT_BITS-1:0] middle_val;

	glmf_push_t        push;
	glmf_rec_t         head;
	logic              q_valid;
	logic [FIFO_AW:0]  q_count;
	logic [FIFO_AW+1:0] q_need;
	logic              pop;

	// register port, write on the access cycle
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign restart = cfg_wr && (paddr[2:2] == REG_GRID_SIDE);
	assign prdata  = (paddr[2:2] == REG_GRID_SIDE) ? 32'(side_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (restart) begin
			side_q <= pwdata[SIDE_W-1:0];
		end
	end

	// clamp side into 1..MAX_SIDE
	always_comb begin
		if (side_q == '0) begin
			eff_side = CMP_W'(1);
		end else if (CMP_W'(side_q) > CMP_W'(MAX_SIDE)) begin
			eff_side = CMP_W'(MAX_SIDE);
		end else begin
			eff_side = CMP_W'(side_q);
		end
	end

	assign last_col  = (CMP_W'(col_q) + CMP_W'(1)) >= eff_side;
	assign last_row  = (CMP_W'(row_q) + CMP_W'(1)) >= eff_side;
	assign is_final  = last_col && last_row;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign sample_in = s_axis_tdata[HEIGHT_BITS-1:0];

	// raster position of the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (restart) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (is_final) begin
				row_q <= '0;
				col_q <= '0;
			end else if (last_col) begin
				row_q <= IDX_W'(row_q + 1'b1);
				col_q <= '0;
			end else begin
				col_q <= IDX_W'(col_q + 1'b1);
			end
		end
	end

	// stage 1 control; the centre cell sits one row and one column back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			fwd_s1 <= 1'b0;
		end else begin
			ctl_s1.valid    <= accept;
			ctl_s1.test     <= (row_q >= IDX_W'(2)) && (col_q >= IDX_W'(2));
			ctl_s1.is_final <= is_final;
			ctl_s1.row      <= IDX_OUT_W'(IDX_W'(row_q - 1'b1));
			ctl_s1.col      <= IDX_OUT_W'(IDX_W'(col_q - 1'b1));
			// the ram returns old data when this read meets the write of stage 1
			fwd_s1          <= ctl_s1.valid && (addr_s1 == col_q);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		sample_s1  <= sample_in;
		addr_s1    <= col_q;
		fwd_up_s1  <= middle_val;
		fwd_mid_s1 <= sample_s1;
	end

	assign upper_val  = fwd_s1 ? fwd_up_s1  : $signed(up_rdata);
	assign middle_val = fwd_s1 ? fwd_mid_s1 : $signed(mid_rdata);

	// row r-2 buffer: takes the old middle row entry
	glmf_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (MAX_SIDE)
	) u_upper_ram (
		.clk   (clk),
		.we    (ctl_s1.valid),
		.waddr (addr_s1),
		.wdata (middle_val),
		.raddr (col_q),
		.rdata (up_rdata)
	);

	// row r-1 buffer: takes the new sample
	glmf_ram #(
		.WIDTH (HEIGHT_BITS),
		.DEPTH (MAX_SIDE)
	) u_middle_ram (
		.clk   (clk),
		.we    (ctl_s1.valid),
		.waddr (addr_s1),
		.wdata (sample_s1),
		.raddr (col_q),
		.rdata (mid_rdata)
	);

	glmf_peak #(
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_peak (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.ctl     (ctl_s1),
		.sample  (sample_s1),
		.upper   (upper_val),
		.middle  (middle_val),
		.push    (push)
	);

	glmf_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.count     (q_count)
	);

	// room for two records from stage 1 and two from the next sample
	assign q_need = (FIFO_AW+2)'(q_count) + (ctl_s1.valid ? (FIFO_AW+2)'(2) : '0)
		+ (FIFO_AW+2)'(2);
	assign s_axis_tready = (q_need <= (FIFO_AW+2)'(FIFO_DEPTH));

	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tvalid = q_valid;
	assign m_axis_tdata  = {head.total, head.col, head.row, head.height};
	assign m_axis_tuser  = head.kind;
	assign m_axis_tlast  = head.last;

endmodule

FILE: src/glmf_checker.sv
// ----------------------------------------------------------------------------
// glmf_checker
// port-level checks of the result stream, bound to the top level
// ----------------------------------------------------------------------------
`include "grid_local_maximum_finder_defines.svh"

module glmf_checker import glmf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]            m_axis_tuser,
	input logic                  m_axis_tlast
);

	// a total record closes the records of its sample
	`GLMF_ASSERT_SAME(a_total_last, m_axis_tvalid && (m_axis_tuser[0] == KIND_TOTAL), m_axis_tlast, "total record without tlast")

	// a total record carries nothing but the count
	`GLMF_ASSERT_SAME(a_total_clean, m_axis_tvalid && (m_axis_tuser[0] == KIND_TOTAL), m_axis_tdata[35:0] == '0, "total record with peak fields set")

	// peaks never sit in row 0 or column 0, and a peak record has no count
	`GLMF_ASSERT_SAME(a_peak_inner, m_axis_tvalid && (m_axis_tuser[0] == KIND_PEAK), (m_axis_tdata[25:16] != '0) && (m_axis_tdata[35:26] != '0) && (m_axis_tdata[55:36] == '0), "peak record on border or with count")

	// a stalled record holds
	`GLMF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled record changed")

endmodule

bind grid_local_maximum_finder glmf_checker u_glmf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: grid local maximum finder testbench
// streams square height grids through the block and checks every peak and
// total record against a local predictor of the 3x3 strict maximum search
// ----------------------------------------------------------------------------
module tb;
	import glmf_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int SETTLE_CYCLES = 8;     // samples with no result still in the pipe
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
	localparam int QUIET_LIMIT   = 4000;  // cycles with no accepted request
	localparam int RANDOM_ITEMS  = 300;
	localparam int SIDE_MAX      = MAX_SIDE_DEF;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_AW-1:0]     paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [15:0]           s_axis_tdata = '0;   // height
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;         // peak_height, peak_row, peak_col, total
	logic [0:0]            m_axis_tuser;         // kind
	logic                  m_axis_tlast;

	grid_local_maximum_finder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// shared run state
	bit          idle_en = 1'b1;
	bit          hold_request = 1'b0;
	int unsigned err_count = 0;
	int unsigned samples_sent = 0;
	int unsigned random_items = 0;
	int unsigned side_writes = 0;
	int unsigned peaks_seen = 0;
	int unsigned totals_seen = 0;

	// predictor state: two previous rows, last two window columns, raster position
	logic signed [15:0]  row_above2 [SIDE_MAX];
	logic signed [15:0]  row_above1 [SIDE_MAX];
	logic signed [15:0]  win [3][2];      // [top,mid,bot][col c-2, col c-1]
	logic [SIDE_W-1:0]   side_reg = SIDE_RESET;
	int unsigned         cur_row = 0;
	int unsigned         cur_col = 0;
	logic [COUNT_W-1:0]  peak_total = '0;
	glmf_rec_t           peak_records_due [$];

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	task automatic restart_grid();
		cur_row = 0;
		cur_col = 0;
		peak_total = '0;
	endtask

	// work out the records caused by one accepted sample
	task automatic predict_sample(input logic signed [15:0] h);
		logic signed [15:0] col_v [3];
		logic signed [15:0] ctr;
		glmf_rec_t          recs [2];
		int unsigned        side;
		int                 n;
		bit                 is_peak;

		n = 0;
		side = (side_reg == 0) ? 1 : ((side_reg > SIDE_MAX) ? SIDE_MAX : side_reg);
		col_v[0] = row_above2[cur_col];
		col_v[1] = row_above1[cur_col];
		col_v[2] = h;

		// the window center is tested when its bottom-right neighbor arrives
		if (cur_row >= 2 && cur_col >= 2) begin
			ctr = win[1][1];
			is_peak = 1'b1;
			for (int k = 0; k < 3; k++) begin
				if (win[k][0] >= ctr) is_peak = 1'b0;
				if (k != 1 && win[k][1] >= ctr) is_peak = 1'b0;
				if (col_v[k] >= ctr) is_peak = 1'b0;
			end
			if (is_peak) begin
				recs[n] = '0;
				recs[n].kind = KIND_PEAK;
				recs[n].height = ctr;
				recs[n].row = IDX_OUT_W'(cur_row - 1);
				recs[n].col = IDX_OUT_W'(cur_col - 1);
				n++;
				peak_total = peak_total + 1'b1;
			end
		end

		for (int k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = col_v[k];
		end
		row_above2[cur_col] = row_above1[cur_col];
		row_above1[cur_col] = h;

		if (cur_row + 1 >= side && cur_col + 1 >= side) begin
			recs[n] = '0;
			recs[n].kind = KIND_TOTAL;
			recs[n].total = peak_total[TOTAL_W-1:0];
			n++;
			restart_grid();
		end else if (cur_col + 1 >= side) begin
			cur_col = 0;
			cur_row++;
		end else begin
			cur_col++;
		end

		if (n > 0) recs[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			peak_records_due.insert(peak_records_due.size(), recs[i]);
	endtask

	// offer one sample request, with random gaps in front of it
	task automatic send_height(input logic [15:0] h);
		while (idle_en && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= h;
		do @(posedge clk); while (!s_axis_tready);
		predict_sample(h);
		samples_sent++;
	endtask

	// stop offering and wait until the block is idle
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (peak_records_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_side_readback(input logic [SIDE_W-1:0] want);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= APB_AW'(4 * REG_GRID_SIDE);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(want)) report_mismatch("grid_side readback", prdata, want);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register writes only land while nothing is in flight
	task automatic write_grid_side(input logic [31:0] value);
		drain_results();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= APB_AW'(4 * REG_GRID_SIDE);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		side_reg = value[SIDE_W-1:0];
		restart_grid();
		side_writes++;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		check_side_readback(value[SIDE_W-1:0]);
	endtask

	// mix of full-range values, narrow values that tie a lot, and the extremes
	function automatic logic [15:0] rand_height();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) return 16'($urandom);
		if (pick < 8) return 16'($urandom_range(0, 4) - 2);
		return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
	endfunction

	task automatic test_reset_value();
		check_side_readback(SIDE_RESET);
	endtask

	// sides 0, 1 and 2 have no interior: every grid ends with a zero total
	task automatic test_tiny_grids();
		write_grid_side(0);
		send_height(16'h7fff);
		write_grid_side(1);
		send_height(16'h8000);
		write_grid_side(2);
		send_height(16'h0000);
		send_height(16'hffff);
		send_height(16'h7fff);
		send_height(16'h8000);
	endtask

	// 3x3 grid whose only interior cell peaks on the final sample
	task automatic test_peak_on_final();
		write_grid_side(3);
		for (int i = 0; i < 9; i++) send_height((i == 4) ? 16'h7fff : 16'h8000);
	endtask

	// next grid without a write: a flat grid must not peak (strictly greater)
	task automatic test_strict_ties();
		for (int i = 0; i < 9; i++) send_height(16'h8000);
	endtask

	// side above the maximum acts as the maximum; a single sample, then restart
	task automatic test_wide_side();
		write_grid_side(32'h7ff);
		send_height(16'h5555);
	endtask

	// receiver holds off while side 3 grids, each with one peak, keep streaming in
	task automatic test_backpressure();
		logic [15:0] h;
		write_grid_side(3);
		hold_request = 1'b1;
		for (int g = 0; g < 20; g++) begin
			for (int i = 0; i < 9; i++) begin
				h = rand_height();
				if (i == 4) h = 16'h7fff;
				else if (h == 16'h7fff) h = 16'h7ffe;
				send_height(h);
				random_items++;
			end
		end
	endtask

	// full small grids back to back, plus partial larger grids cut short by a write
	task automatic test_random_grids();
		int unsigned side;
		int unsigned eff;
		int unsigned n;
		bit          partial;
		while (random_items < RANDOM_ITEMS + 180) begin
			// one stretch with no idling on either side
			idle_en = !(random_items >= 300 && random_items < 420);
			partial = ($urandom_range(0, 4) == 0);
			if (partial) side = $urandom_range(10, 40);
			else if ($urandom_range(0, 9) == 0) side = $urandom_range(0, 2);
			else side = $urandom_range(3, 9);
			eff = (side == 0) ? 1 : side;
			write_grid_side(side);
			if (partial) n = side * $urandom_range(2, 4) + $urandom_range(0, side - 1);
			else n = eff * eff * $urandom_range(1, 3);
			repeat (n) begin
				send_height(rand_height());
				random_items++;
			end
		end
		idle_en = 1'b1;
	endtask

	// receiver: random stalls, and one long hold-off on request
	initial begin
		int hold_cnt;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
			end
			m_axis_tready <= (!idle_en || $urandom_range(0, 99) >= 11);
		end
	end

	// result checker: each accepted record against the oldest one due
	always @(posedge clk) begin
		glmf_rec_t got;
		glmf_rec_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser[0];
			got.height = m_axis_tdata[15:0];
			got.row = m_axis_tdata[25:16];
			got.col = m_axis_tdata[35:26];
			got.total = m_axis_tdata[55:36];
			got.last = m_axis_tlast;
			if (peak_records_due.size() == 0) begin
				report_mismatch("record with none due", m_axis_tdata, 0);
			end else begin
				want = peak_records_due.pop_front();
				if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
				if (got.height != want.height)
					report_mismatch("peak_height", got.height, want.height);
				if (got.row != want.row) report_mismatch("peak_row", got.row, want.row);
				if (got.col != want.col) report_mismatch("peak_col", got.col, want.col);
				if (got.total != want.total) report_mismatch("total", got.total, want.total);
				if (got.last != want.last) report_mismatch("last", got.last, want.last);
				if (want.kind == KIND_PEAK) peaks_seen++;
				else totals_seen++;
			end
		end
	end

	// watchdog: too long with no accepted request on either stream
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_value();
		test_tiny_grids();
		test_peak_on_final();
		test_strict_ties();
		test_wide_side();
		test_backpressure();
		test_random_grids();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (peak_records_due.size() != 0)
			report_mismatch("records never delivered", peak_records_due.size(), 0);

		$display("run covered %0d samples over %0d grid_side writes", samples_sent, side_writes);
		$display("checked %0d peak records and %0d total records", peaks_seen, totals_seen);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/glmf_pkg.sv
src/glmf_ram.sv
src/glmf_peak.sv
src/glmf_fifo.sv
src/grid_local_maximum_finder.sv
src/glmf_checker.sv
dv/tb.sv
